// ----- rtl/core/rbri_pkg.sv -----
`timescale 1ns / 1ps
package rbri_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 4;
  localparam int OCC_W    = 5;
  localparam int FUNC_W   = 2;
  localparam int STAT_W   = 2;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 2'd0,
    FN_REMOVE = 2'd1,
    FN_READ   = 2'd2
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // direction in which the cells close a gap
  typedef enum logic [1:0] {
    MV_NONE,
    MV_UP,    // entries before the index move toward the tail
    MV_DOWN   // entries after the index move toward the head
  } move_t;

  typedef struct packed {
    move_t mv;
    slot_t head;
    slot_t idx;
    cnt_t  count;
    logic  load;
    slot_t load_slot;
    word_t load_data;
  } cmd_t;

endpackage

// ----- rtl/core/ring_buffer_remove_at_index.sv -----
`timescale 1ns / 1ps
// An accepted item's result lands in the output register on the next cycle.
// Throughput: one item per cycle while no result waits under out_stall; a removal closes
// the gap at once, each cell between the index and the moving end copying its neighbor.
// The output register is the only stage, so input stalls only when a result waits.
// Reset (rst, synchronous) empties the store: head, tail and count go to zero.
module ring_buffer_remove_at_index (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rbri_pkg::FUNC_W-1:0] func,
  input  logic [rbri_pkg::POS_W-1:0]  position,
  input  logic [rbri_pkg::DATA_W-1:0] write_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rbri_pkg::DATA_W-1:0] read_value,
  output logic [rbri_pkg::STAT_W-1:0] status,
  output logic [rbri_pkg::OCC_W-1:0]  occupancy
);

  rbri_pkg::word_t words [rbri_pkg::CAPACITY];
  rbri_pkg::cmd_t  cmd;

  rbri_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .position    (position),
    .write_value (write_value),
    .words       (words),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value),
    .status      (status),
    .occupancy   (occupancy)
  );

  for (genvar i = 0; i < rbri_pkg::CAPACITY; i++) begin : g_cell
    rbri_cell u_cell (
      .clk       (clk),
      .slot      (rbri_pkg::SLOT_W'(i)),
      .cmd       (cmd),
      .prev_word (words[(i + rbri_pkg::CAPACITY - 1) % rbri_pkg::CAPACITY]),
      .next_word (words[(i + 1) % rbri_pkg::CAPACITY]),
      .word      (words[i])
    );
  end

endmodule

// ----- rtl/core/rbri_cell.sv -----
`timescale 1ns / 1ps
module rbri_cell (
  input  logic            clk,
  input  rbri_pkg::slot_t slot,
  input  rbri_pkg::cmd_t  cmd,
  input  rbri_pkg::word_t prev_word,
  input  rbri_pkg::word_t next_word,
  output rbri_pkg::word_t word
);

  rbri_pkg::slot_t lidx;
  rbri_pkg::cnt_t  lidx_inc;
  logic            take_prev;
  logic            take_next;
  logic            take_load;
  rbri_pkg::word_t word_next;

  // logical position of this slot relative to the head
  always_comb begin
    if (slot >= cmd.head) begin
      lidx = slot - cmd.head;
    end else begin
      lidx = rbri_pkg::SLOT_W'(rbri_pkg::CNT_W'(slot)
                               + rbri_pkg::CNT_W'(rbri_pkg::CAPACITY)
                               - rbri_pkg::CNT_W'(cmd.head));
    end
    lidx_inc  = rbri_pkg::CNT_W'(lidx) + rbri_pkg::CNT_W'(1);
    take_prev = (cmd.mv == rbri_pkg::MV_UP) && (lidx != '0) && (lidx <= cmd.idx);
    take_next = (cmd.mv == rbri_pkg::MV_DOWN) && (lidx >= cmd.idx)
                && (lidx_inc < cmd.count);
    take_load = cmd.load && (slot == cmd.load_slot);
  end

  always_comb begin
    priority if (take_load) begin
      word_next = cmd.load_data;
    end else if (take_prev) begin
      word_next = prev_word;
    end else if (take_next) begin
      word_next = next_word;
    end else begin
      word_next = word;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ----- rtl/core/rbri_ctrl.sv -----
`timescale 1ns / 1ps
module rbri_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rbri_pkg::FUNC_W-1:0] func,
  input  logic [rbri_pkg::POS_W-1:0]  position,
  input  rbri_pkg::word_t             write_value,
  input  rbri_pkg::word_t             words [rbri_pkg::CAPACITY],
  output rbri_pkg::cmd_t              cmd,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rbri_pkg::word_t             read_value,
  output logic [rbri_pkg::STAT_W-1:0] status,
  output logic [rbri_pkg::OCC_W-1:0]  occupancy
);

  rbri_pkg::slot_t   head;
  rbri_pkg::slot_t   tail;
  rbri_pkg::cnt_t    count;
  rbri_pkg::slot_t   head_next;
  rbri_pkg::slot_t   tail_next;
  rbri_pkg::cnt_t    count_next;
  rbri_pkg::word_t   rval;
  rbri_pkg::status_t stat;
  logic              accept;
  rbri_pkg::cnt_t    pos_c;
  rbri_pkg::cnt_t    rd_sum;
  rbri_pkg::slot_t   rd_slot;
  logic              in_range;
  rbri_pkg::slot_t   head_inc;
  rbri_pkg::slot_t   tail_inc;
  rbri_pkg::slot_t   tail_dec;

  function automatic rbri_pkg::slot_t slot_inc(rbri_pkg::slot_t s);
    return (rbri_pkg::CNT_W'(s) == rbri_pkg::CNT_W'(rbri_pkg::CAPACITY - 1))
           ? '0 : s + rbri_pkg::SLOT_W'(1);
  endfunction

  function automatic rbri_pkg::slot_t slot_dec(rbri_pkg::slot_t s);
    return (s == '0) ? rbri_pkg::SLOT_W'(rbri_pkg::CAPACITY - 1)
                     : s - rbri_pkg::SLOT_W'(1);
  endfunction

  // output register frees as it is taken, so one item a cycle
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    pos_c    = rbri_pkg::CNT_W'(position);
    in_range = pos_c < count;
    rd_sum   = rbri_pkg::CNT_W'(head) + pos_c;
    if (rd_sum >= rbri_pkg::CNT_W'(rbri_pkg::CAPACITY)) begin
      rd_slot = rbri_pkg::SLOT_W'(rd_sum - rbri_pkg::CNT_W'(rbri_pkg::CAPACITY));
    end else begin
      rd_slot = rbri_pkg::SLOT_W'(rd_sum);
    end
    head_inc = slot_inc(head);
    tail_inc = slot_inc(tail);
    tail_dec = slot_dec(tail);
  end

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    rval          = '0;
    stat          = rbri_pkg::ST_OK;
    cmd.mv        = rbri_pkg::MV_NONE;
    cmd.head      = head;
    cmd.idx       = rbri_pkg::SLOT_W'(position);
    cmd.count     = count;
    cmd.load      = 1'b0;
    cmd.load_slot = (count == '0) ? head : tail_inc;
    cmd.load_data = write_value;
    if (accept) begin
      unique case (func)
        rbri_pkg::FN_APPEND: begin
          if (count == rbri_pkg::CNT_W'(rbri_pkg::CAPACITY)) begin
            stat = rbri_pkg::ST_FULL;
          end else begin
            cmd.load   = 1'b1;
            tail_next  = cmd.load_slot;
            count_next = count + rbri_pkg::CNT_W'(1);
          end
        end
        rbri_pkg::FN_REMOVE: begin
          if (!in_range) begin
            stat = rbri_pkg::ST_RANGE;
          end else begin
            if (count != rbri_pkg::CNT_W'(1)) begin
              if (pos_c < (count >> 1)) begin
                cmd.mv    = rbri_pkg::MV_UP;
                head_next = head_inc;
              end else begin
                cmd.mv    = rbri_pkg::MV_DOWN;
                tail_next = tail_dec;
              end
            end
            count_next = count - rbri_pkg::CNT_W'(1);
          end
        end
        rbri_pkg::FN_READ: begin
          if (!in_range) begin
            stat = rbri_pkg::ST_RANGE;
          end else begin
            rval = words[rd_slot];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= rval;
      status     <= stat;
      occupancy  <= rbri_pkg::OCC_W'(count_next);
    end
  end

endmodule

// ----- rtl/core/rbri_checker.sv -----
`timescale 1ns / 1ps
module rbri_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [rbri_pkg::DATA_W-1:0] read_value,
  input logic [rbri_pkg::STAT_W-1:0] status,
  input logic [rbri_pkg::OCC_W-1:0]  occupancy
);

  // every accepted item leaves a result behind
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted item produced no result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_value)
                                  && $stable(status) && $stable(occupancy)))
    else $error("stalled result changed");

  a_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == rbri_pkg::ST_FULL)
      |-> (occupancy == rbri_pkg::OCC_W'(rbri_pkg::CAPACITY)))
    else $error("full status with store not full");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != rbri_pkg::ST_OK) |-> (read_value == '0))
    else $error("error result carries data");

  a_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (occupancy <= rbri_pkg::OCC_W'(rbri_pkg::CAPACITY)))
    else $error("occupancy above capacity");

endmodule

bind ring_buffer_remove_at_index rbri_checker u_rbri_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .read_value (read_value),
  .status     (status),
  .occupancy  (occupancy)
);

// ----- test/tb_ring_buffer_remove_at_index.sv -----
`timescale 1ns / 1ps
module tb_ring_buffer_remove_at_index;
  import rbri_pkg::*;

  localparam logic [FUNC_W-1:0] FN_NOP = 2'd3;  // unused code, no operation
  localparam int RANDOM_ITEMS   = 830;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 4;

  typedef struct {
    word_t             rd;
    logic [STAT_W-1:0] st;
    logic [OCC_W-1:0]  occ;
  } outcome_t;

  // Shadow copy of the ring: predicts the outcome of each accepted item.
  class ring_shadow;
    word_t    slots[CAPACITY];
    int       head;
    int       tail;
    int       fill;
    int       errors;
    outcome_t awaited_outcomes[$];

    function void note_op(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p, word_t w);
      outcome_t o;
      int       j;
      o.rd = '0;
      o.st = ST_OK;
      case (f)
        FN_APPEND: begin
          if (fill >= CAPACITY) begin
            o.st = ST_FULL;
          end else begin
            if (fill == 0) tail = head;
            else tail = (tail + 1) % CAPACITY;
            slots[tail] = w;
            fill++;
          end
        end
        FN_REMOVE: begin
          if (p >= fill) begin
            o.st = ST_RANGE;
          end else begin
            if (fill != 1) begin
              if (p < fill / 2) begin
                // shift the front part toward the tail
                for (j = p; j != 0; j--)
                  slots[(head + j) % CAPACITY] = slots[(head + j - 1) % CAPACITY];
                head = (head + 1) % CAPACITY;
              end else begin
                for (j = p; j + 1 < fill; j++)
                  slots[(head + j) % CAPACITY] = slots[(head + j + 1) % CAPACITY];
                tail = (tail + CAPACITY - 1) % CAPACITY;
              end
            end
            fill--;
          end
        end
        FN_READ: begin
          if (p >= fill) o.st = ST_RANGE;
          else o.rd = slots[(head + p) % CAPACITY];
        end
        default: ;
      endcase
      o.occ = OCC_W'(fill);
      awaited_outcomes.push_back(o);
    endfunction

    function void check_result(word_t rv, logic [STAT_W-1:0] st, logic [OCC_W-1:0] occ);
      outcome_t o;
      if (awaited_outcomes.size() == 0) begin
        $error("result with no item awaiting it");
        errors++;
        return;
      end
      o = awaited_outcomes.pop_front();
      if (rv !== o.rd) begin
        $error("read_value expected %h actual %h", o.rd, rv);
        errors++;
      end
      if (st !== o.st) begin
        $error("status expected %0d actual %0d", o.st, st);
        errors++;
      end
      if (occ !== o.occ) begin
        $error("occupancy expected %0d actual %0d", o.occ, occ);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] func = FN_NOP;
  logic [POS_W-1:0]  position = '0;
  word_t             write_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  word_t             read_value;
  logic [STAT_W-1:0] status;
  logic [OCC_W-1:0]  occupancy;

  ring_shadow shadow = new();
  bit         calm = 1'b0;   // no idling on either side while set
  int         hold_ask = 0;
  int         hold_seen = 0;
  int         sent_fill = 0; // entry count as the sender sees it
  int         quiet = 0;

  ring_buffer_remove_at_index dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .position   (position),
    .write_value(write_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .status     (status),
    .occupancy  (occupancy)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) shadow.note_op(func, position, write_value);
      if (out_valid && !out_stall) shadow.check_result(read_value, status, occupancy);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb_ring_buffer_remove_at_index failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm && !rst && ($urandom_range(99) < 10);
    end
  end

  task automatic send_item(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p, word_t w);
    func        <= f;
    position    <= p;
    write_value <= w;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    case (f)
      FN_APPEND: if (sent_fill < CAPACITY) sent_fill++;
      FN_REMOVE: if (p < sent_fill) sent_fill--;
      default: ;
    endcase
    if (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (shadow.awaited_outcomes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    int                n;
    int                r;
    bit                grow;
    logic [FUNC_W-1:0] f;
    logic [POS_W-1:0]  p;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store: out-of-range remove and read, then the unused code
    send_item(FN_REMOVE, 4'd0, 32'h0);
    send_item(FN_READ, 4'd15, 32'h0);
    send_item(FN_NOP, 4'd0, 32'h0);
    send_item(FN_APPEND, 4'd0, 32'h0000_0000);
    send_item(FN_APPEND, 4'd0, 32'hFFFF_FFFF);
    send_item(FN_APPEND, 4'd0, 32'h5555_5555);
    send_item(FN_APPEND, 4'd0, 32'hAAAA_AAAA);
    for (n = 4; n < CAPACITY; n++) send_item(FN_APPEND, 4'd0, $urandom);
    send_item(FN_APPEND, 4'd0, $urandom);  // full
    send_item(FN_READ, 4'd15, 32'h0);
    send_item(FN_READ, 4'd0, 32'h0);
    send_item(FN_REMOVE, 4'd2, 32'h0);     // front half closes toward the tail
    send_item(FN_REMOVE, 4'd12, 32'h0);    // back half closes toward the head
    send_item(FN_REMOVE, 4'd13, 32'h0);    // last entry
    send_item(FN_REMOVE, 4'd0, 32'h0);
    pause_until_drained();

    grow = 1'b1;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 250) hold_ask++;
      if (n == 450) pause_until_drained();
      if (n == 550) calm = 1'b1;
      if (n == 680) calm = 1'b0;

      if (sent_fill == 0) grow = 1'b1;
      else if (sent_fill == CAPACITY && $urandom_range(3) == 0) grow = 1'b0;
      else if ($urandom_range(99) < 4) grow = !grow;

      r = $urandom_range(99);
      if (r < 3) f = FN_NOP;
      else if (grow) f = (r < 70) ? FN_APPEND : (r < 85) ? FN_REMOVE : FN_READ;
      else f = (r < 65) ? FN_REMOVE : (r < 80) ? FN_APPEND : FN_READ;

      if (sent_fill > 0 && $urandom_range(99) < 88) p = POS_W'($urandom_range(sent_fill - 1));
      else p = POS_W'($urandom_range(15));

      send_item(f, p, $urandom);
    end

    pause_until_drained();
    if (shadow.awaited_outcomes.size() != 0) shadow.errors++;
    if (shadow.errors == 0) begin
      $display("tb_ring_buffer_remove_at_index passed");
    end else begin
      $display("tb_ring_buffer_remove_at_index failed");
    end
    $finish;
  end

endmodule

// ----- ring_buffer_remove_at_index.f -----
rtl/core/rbri_pkg.sv
rtl/core/rbri_cell.sv
rtl/core/rbri_ctrl.sv
rtl/core/ring_buffer_remove_at_index.sv
rtl/core/rbri_checker.sv
test/tb_ring_buffer_remove_at_index.sv
